FILE: src/hst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HMAC-SHA-256 tag engine package
// Payload types, SHA-256 constants and round functions.
// ----------------------------------------------------------------------------
package hst_pkg;

    localparam int KEY_WORDS   = 8;
    localparam int TAG_WORDS   = 4;
    localparam int DIGEST_BYTES = 32;
    localparam int PADDR_W     = 6;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TAG  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [7:0]  message_byte;
        logic        last_byte;
        logic [5:0]  tag_bytes;
        logic [63:0] expected_word;
        logic [1:0]  expected_index;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
        logic        tag_match;
    } t_out_item;

    typedef logic [31:0] t_word;
    typedef t_word [7:0] t_hash;

    localparam t_hash INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic t_word round_k(input logic [5:0] i);
        t_word k;
        case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: src/hmac_sha256_tag_engine_top.sv
`timescale 1ns / 1ps
// A message byte that fills a 64-byte block adds one compression, the first
// byte of a message adds one for the inner key block, and the last byte adds
// 3 to 4 compressions and a byte-wise compare of up to 32 tag bytes before
// four result transactions, one per accepted cycle. All compressions run on
// the one-round-per-cycle compression core. Tag items load one expected word.
// Reset clears keys, tag and state.
// ----------------------------------------------------------------------------
// HMAC-SHA-256 tag engine
// Byte-stream HMAC with APB key registers and expected-tag compare.
// ----------------------------------------------------------------------------
module hmac_sha256_tag_engine_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  hst_pkg::t_in_item     i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output hst_pkg::t_out_item    o_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [hst_pkg::PADDR_W-1:0] paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);
    import hst_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_IKEY  = 4'd1;
    localparam logic [3:0] S_IKEYW = 4'd2;
    localparam logic [3:0] S_PUT   = 4'd3;
    localparam logic [3:0] S_BLKW  = 4'd4;
    localparam logic [3:0] S_PAD   = 4'd5;
    localparam logic [3:0] S_PADW  = 4'd6;
    localparam logic [3:0] S_OKEY  = 4'd7;
    localparam logic [3:0] S_OKEYW = 4'd8;
    localparam logic [3:0] S_OUTR  = 4'd9;
    localparam logic [3:0] S_OUTW  = 4'd10;
    localparam logic [3:0] S_CMP   = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;

    logic [3:0]    r_state;
    logic [63:0]   r_key [KEY_WORDS];
    logic [63:0]   r_tag [TAG_WORDS];
    t_hash         r_h;
    t_hash         r_inner;
    t_word [15:0]  r_blk;
    logic [63:0]   r_len;
    logic          r_in_msg;
    logic          r_last;
    logic          r_final_pad;
    logic [5:0]    r_nbytes;
    logic [5:0]    r_cidx;
    logic          r_match;
    logic [1:0]    r_widx;
    t_in_item      r_item;

    logic          core_start, core_done;
    t_hash         core_h_in, core_h;
    t_word [15:0]  core_blk;

    hst_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(core_start),
        .i_h(core_h_in), .i_blk(core_blk), .o_done(core_done), .o_h(core_h)
    );

    t_word [15:0] key_blk;
    t_word [15:0] put_blk;
    t_word [15:0] fin_blk;
    logic         pad_o;
    logic [63:0]  bits;
    logic [5:0]   pos;
    logic [3:0]   wsel;
    logic [1:0]   bsel;

    always_comb begin
        pos  = r_len[5:0];
        wsel = pos[5:2];
        bsel = pos[1:0];
        bits = (r_len + 64'd64) << 3;
        pad_o = (r_state == S_OKEY);
        for (int i = 0; i < 8; i++) begin
            key_blk[2*i]   = r_key[i][63:32] ^ (pad_o ? 32'h5c5c5c5c : 32'h36363636);
            key_blk[2*i+1] = r_key[i][31:0]  ^ (pad_o ? 32'h5c5c5c5c : 32'h36363636);
        end
        core_start = 1'b0;
        core_h_in  = r_h;
        core_blk   = r_blk;
        case (r_state)
            S_IKEY, S_OKEY: begin
                core_start = 1'b1;
                core_h_in  = INIT_H;
                core_blk   = key_blk;
            end
            S_PUT: begin
                core_start = (r_len[5:0] == 6'd63);
                core_blk   = put_blk;
            end
            S_PAD: begin
                core_start = 1'b1;
                if (r_final_pad) begin
                    core_blk[14] = bits[63:32];
                    core_blk[15] = bits[31:0];
                end
            end
            S_OUTR: begin
                core_start = 1'b1;
                core_h_in  = r_h;
                core_blk   = {32'd768, 192'h0, 32'h80000000, r_inner};
            end
            default: ;
        endcase
    end

    // byte insert into the block buffer
    function automatic t_word ins(input t_word w, input logic [1:0] b, input logic [7:0] v);
        t_word r;
        case (b)
            2'd0: r = {v, 24'h0};
            2'd1: r = {w[31:24], v, 16'h0};
            2'd2: r = {w[31:16], v, 8'h0};
            2'd3: r = {w[31:8], v};
            default: r = w;
        endcase
        return r;
    endfunction

    logic [63:0] dig_w, tag_w;
    logic [7:0]  db, tb;
    always_comb begin
        put_blk = r_blk;
        put_blk[wsel] = ins(r_blk[wsel], bsel, r_item.message_byte);
        fin_blk = put_blk;
        for (int i = 0; i < 16; i++) begin
            if (4'(i) > wsel) fin_blk[i] = '0;
        end
        if (bsel == 2'd3) begin
            if (wsel != 4'd15) fin_blk[wsel + 4'd1] = 32'h80000000;
        end else begin
            fin_blk[wsel] = ins(put_blk[wsel], bsel + 2'd1, 8'h80);
        end
        dig_w = {r_h[{r_cidx[4:3], 1'b0}], r_h[{r_cidx[4:3], 1'b1}]};
        tag_w = r_tag[r_cidx[4:3]];
        db = dig_w[{~r_cidx[2:0], 3'b000} +: 8];
        tb = tag_w[{~r_cidx[2:0], 3'b000} +: 8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_in_msg <= 1'b0;
            r_len    <= '0;
            r_h      <= INIT_H;
            r_widx   <= '0;
            for (int i = 0; i < KEY_WORDS; i++) r_key[i] <= '0;
            for (int i = 0; i < TAG_WORDS; i++) r_tag[i] <= '0;
        end else begin
            if (psel && penable && pwrite)
                r_key[paddr[5:3]] <= pwdata;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_item <= i_data;
                        if (i_data.action == ACT_TAG) begin
                            r_tag[i_data.expected_index] <= i_data.expected_word;
                        end else if (!r_in_msg) begin
                            r_state <= S_IKEY;
                        end else begin
                            r_state <= S_PUT;
                        end
                    end
                end
                S_IKEY:  r_state <= S_IKEYW;
                S_IKEYW: if (core_done) begin
                    r_h      <= core_h;
                    r_len    <= '0;
                    r_in_msg <= 1'b1;
                    r_state  <= S_PUT;
                end
                S_PUT: begin
                    r_blk <= (r_item.last_byte && pos != 6'd63) ? fin_blk : put_blk;
                    r_len <= r_len + 64'd1;
                    r_last <= r_item.last_byte;
                    r_nbytes <= (r_item.tag_bytes > 6'(DIGEST_BYTES)) ?
                                6'(DIGEST_BYTES) : r_item.tag_bytes;
                    if (pos == 6'd63) r_state <= S_BLKW;
                    else if (r_item.last_byte) r_state <= S_PAD;
                    else r_state <= S_IDLE;
                    r_final_pad <= r_item.last_byte && (pos < 6'd55);
                end
                S_BLKW: if (core_done) begin
                    r_h <= core_h;
                    if (r_last) begin
                        r_blk <= {480'h0, 32'h80000000};
                        r_final_pad <= 1'b1;
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PAD: begin
                    r_state <= S_PADW;
                end
                S_PADW: if (core_done) begin
                    r_h <= core_h;
                    if (r_final_pad) begin
                        r_inner <= core_h;
                        r_state <= S_OKEY;
                    end else begin
                        r_blk <= '0;
                        r_final_pad <= 1'b1;
                        r_state <= S_PAD;
                    end
                end
                S_OKEY:  r_state <= S_OKEYW;
                S_OKEYW: if (core_done) begin
                    r_h <= core_h;
                    r_state <= S_OUTR;
                end
                S_OUTR:  r_state <= S_OUTW;
                S_OUTW:  if (core_done) begin
                    r_h <= core_h;
                    r_cidx <= '0;
                    r_match <= 1'b1;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_cidx == r_nbytes) begin
                        r_widx <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        if (db != tb) r_match <= 1'b0;
                        r_cidx <= r_cidx + 6'd1;
                    end
                end
                S_EMIT: if (i_ready) begin
                    r_widx <= r_widx + 2'd1;
                    if (r_widx == 2'd3) begin
                        r_in_msg <= 1'b0;
                        r_len    <= '0;
                        r_h      <= INIT_H;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // S_PAD before the length block: when length fits (pos<56 after 0x80),
    // the 0x80 block is final; otherwise an extra zero block follows.
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_EMIT);
    always_comb begin
        o_data.digest_word = {r_h[{r_widx, 1'b0}], r_h[{r_widx, 1'b1}]};
        o_data.word_index  = r_widx;
        o_data.last_word   = (r_widx == 2'd3);
        o_data.tag_match   = r_match;
    end

    assign pready = 1'b1;
    assign prdata = r_key[paddr[5:3]];

    ap_emit_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_in_msg) else $error("result outside message");
    ap_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready during emit");
    ap_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_start |-> !$past(core_start)) else $error("double start");

endmodule

FILE: src/hst_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HMAC-SHA-256 compression core
// One SHA-256 round per cycle with a rolling 16-word schedule; 64 rounds and
// a final add into the chaining value.
// ----------------------------------------------------------------------------
module hst_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  hst_pkg::t_hash    i_h,
    input  hst_pkg::t_word [15:0] i_blk,
    output logic              o_done,
    output hst_pkg::t_hash    o_h
);
    import hst_pkg::*;

    logic          r_busy;
    logic [5:0]    r_rnd;
    t_hash         r_base;
    t_hash         r_v;
    t_word [15:0]  r_w;
    logic          r_done;

    t_word s0, s1, t1, t2, w_new, ch, mj, e, a;
    t_hash n_v;

    always_comb begin
        a  = r_v[0];
        e  = r_v[4];
        ch = (e & r_v[5]) ^ (~e & r_v[6]);
        mj = (a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch + round_k(r_rnd) + r_w[0];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + mj;
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        n_v = {r_v[6], r_v[5], r_v[4], r_v[3] + t1, r_v[2], r_v[1], r_v[0], t1 + t2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_base <= i_h;
            r_v    <= i_h;
            r_w    <= i_blk;
        end else if (r_busy) begin
            r_v <= n_v;
            r_w <= {w_new, r_w[15:1]};
            if (r_rnd == 6'd63) begin
                for (int i = 0; i < 8; i++) r_base[i] <= r_base[i] + n_v[i];
            end
        end
    end

    assign o_done = r_done;
    assign o_h    = r_base;

    ap_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_rnd != 6'd63 |=> r_busy) else $error("core dropped busy early");
    ap_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");
    ap_done_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without work");

endmodule
